>>> rtl/insertion_sorter_unit_macros.svh
// assertion macros for the insertion sorter
`ifndef INSERTION_SORTER_UNIT_MACROS_SVH
`define INSERTION_SORTER_UNIT_MACROS_SVH

// implication checked on every clock edge out of reset
`define INS_SORT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// non-overlapping implication, checked out of reset
`define INS_SORT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ins_sort_pkg.sv
// shared types and constants of the insertion sorter
package ins_sort_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W    = 32;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
  } cell_data_t;

  typedef struct packed {
    logic                    ins;
    logic                    drain;
    logic signed [VAL_W-1:0] val;
  } cell_ctl_t;

endpackage

>>> rtl/ins_sort_if.sv
// word channels of the insertion sorter
interface ins_sort_in_if import ins_sort_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ins_sort_out_if import ins_sort_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sorted_value;
  logic                    last_res;
  logic                    overflow;

  modport source (output valid, output sorted_value, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_res, input overflow,
                  output ready);
endinterface

>>> rtl/insertion_sorter_unit.sv
// insertion sorter: chain of compare-and-shift cells with a drain phase
// in_ch takes one signed word per cycle with a flag on the final word of a set.
// each word is broadcast to every cell and lands ahead of the first entry
// greater than or equal to it, the entries behind it shifting along the chain.
// words arriving with all CAPACITY cells full are dropped and flag the set.
// after the final word the chain shifts towards cell 0 and out_ch presents
// one sorted word per cycle, ascending, the greatest one marked by last_res,
// every word of the set carrying overflow if anything was dropped.
// the first result is shown the cycle after the final word is taken.
// a set of n words yields min(n, CAPACITY) sorted words.
// in_ch.ready is low while the chain drains; a stall on out_ch holds the
// chain and the presented word unchanged.
// reset synchronously empties every cell and clears the drain and overflow state.
`include "insertion_sorter_unit_macros.svh"

module insertion_sorter_unit import ins_sort_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  ins_sort_in_if.sink     in_ch,
  ins_sort_out_if.source  out_ch
);

  cell_ctl_t  ctl;
  cell_data_t cdat [CAPACITY];
  logic       cge  [CAPACITY];

  logic drain_r, drain_nxt;
  logic ovf_r, ovf_nxt;
  logic in_acc, out_acc, full;

  assign full    = cdat[CAPACITY-1].vld;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign ctl.ins   = in_acc && !full;
  assign ctl.drain = out_acc;
  assign ctl.val   = in_ch.value;

  assign in_ch.ready         = !drain_r;
  assign out_ch.valid        = drain_r;
  assign out_ch.sorted_value = cdat[0].val;
  assign out_ch.last_res     = !cdat[1].vld;
  assign out_ch.overflow     = ovf_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_data_t ldat, rdat;
    logic       lge;
    if (i == 0) begin : g_head
      assign ldat = '0;
      assign lge  = 1'b0;
    end else begin : g_body
      assign ldat = cdat[i-1];
      assign lge  = cge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rdat = '0;
    end else begin : g_mid
      assign rdat = cdat[i+1];
    end
    ins_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_dat  (ldat),
      .left_ge   (lge),
      .right_dat (rdat),
      .dat       (cdat[i]),
      .ge        (cge[i])
    );
  end

  always_comb begin
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (in_acc) begin
      ovf_nxt = ovf_r || full;
      if (in_ch.last) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_acc && out_ch.last_res) begin
      drain_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `INS_SORT_ASSERT_IMP(a_drain_has_word, drain_r, cdat[0].vld,
                       "drain with empty head cell")
  `INS_SORT_ASSERT_NXT(a_end_empties, out_acc && out_ch.last_res,
                       !drain_r && !cdat[0].vld && !ovf_r,
                       "chain not empty after final word")
  `INS_SORT_ASSERT_NXT(a_insert_fills, ctl.ins, cdat[0].vld,
                       "insert left head cell empty")

endmodule

>>> rtl/ins_sort_cell.sv
// one compare-and-shift cell of the sorting chain
module ins_sort_cell import ins_sort_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_data_t left_dat,
  input  logic       left_ge,
  input  cell_data_t right_dat,
  output cell_data_t dat,
  output logic       ge
);

  logic                    vld_r, vld_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;

  // empty cells count as greater so the flag is monotone along the chain
  assign ge  = !vld_r || ($signed(val_r) >= $signed(ctl.val));
  assign dat = '{vld: vld_r, val: val_r};

  always_comb begin
    priority if (ctl.drain) begin
      vld_nxt = right_dat.vld;
      val_nxt = right_dat.val;
    end else if (ctl.ins && ge) begin
      if (left_ge) begin
        vld_nxt = left_dat.vld;
        val_nxt = left_dat.val;
      end else begin
        vld_nxt = 1'b1;
        val_nxt = ctl.val;
      end
    end else begin
      vld_nxt = vld_r;
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
  end

endmodule
